>>> rtl/core/tas_pkg.sv
// ============================================================================
// tas_pkg: shared definitions for the triangle area sorter
// Sizes, transaction payload types, the stored entry format and the
// controller states used across the sorter's files.
// ============================================================================
package tas_pkg;

	localparam int MAX_TRIANGLES = 64;
	localparam int EDGE_BITS     = 12;
	localparam int FIELD_W       = 12;
	localparam int KEY_W         = 56;
	localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);
	localparam int ADDR_W        = $clog2(MAX_TRIANGLES);
	// Each factor of the key is a signed sum of the edges a, b and c.
	localparam int SUM_W         = EDGE_BITS + 3;
	localparam int PROD_W        = 2 * SUM_W;

	typedef struct packed {
		logic [FIELD_W-1:0] edge_one;
		logic [FIELD_W-1:0] edge_two;
		logic [FIELD_W-1:0] edge_three;
		logic               final_item;
	} tri_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] sorted_one;
		logic [FIELD_W-1:0] sorted_two;
		logic [FIELD_W-1:0] sorted_three;
		logic               not_triangle;
		logic               run_end;
		logic               overflowed;
	} res_t;

	typedef struct packed {
		logic [EDGE_BITS-1:0] e3;
		logic [EDGE_BITS-1:0] e2;
		logic [EDGE_BITS-1:0] e1;
		logic [KEY_W-1:0]     key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY1,
		ST_KEY2,
		ST_KEY3,
		ST_SORT_RD,
		ST_SORT_CAP,
		ST_SCAN,
		ST_WB,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

endpackage

>>> rtl/core/tas_if.sv
// ============================================================================
// tas_if: valid/ready channels of the triangle area sorter
// One channel carries input triangles, the other carries sorted results.
// ============================================================================
interface tas_tri_if import tas_pkg::*; ();
	logic    valid;
	logic    ready;
	tri_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tas_res_if import tas_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/triangle_area_sorter.sv
// ============================================================================
// triangle_area_sorter: exchange sort of triangles by Heron area
// Stores triangles with an exact integer area key and, at the end of a set,
// sorts them in place in RAM and emits them, valid ones in ascending area order.
// ============================================================================
//
//  channel    | direction | payload                                 | per set
//  -----------+-----------+-----------------------------------------+------------
//  triangles  | in        | edge_one/two/three, final_item          | 1..any
//  results    | out       | sorted_one/two/three, not_triangle,     | stored
//             |           | run_end, overflowed                     | count
//
// A triangle transaction passes through the accept, two stages of the key
// unit and the RAM write. On the final transaction the sort runs over the n
// stored entries, bound by the single RAM read port (one compare per cycle),
// then each result is read from RAM and loaded into the result register.
// Reset clears the count, the drop flag and the controller; the RAM is not
// cleared because only entries below the count are ever used.
// The result register lets the next set start loading while the last result
// of a set still waits on a stalled results channel.

module triangle_area_sorter import tas_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tas_tri_if.sink   triangles,
	tas_res_if.source results
);

	state_t state_q, state_d;

	// Transaction capture and set bookkeeping.
	logic [EDGE_BITS-1:0] e1_q, e2_q, e3_q;
	logic                 last_q;
	logic                 store_q;
	logic                 drop_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     cnt_after;

	// Sort and output indexes. They are one bit wider than a RAM address so
	// that they can hold the count itself.
	logic [CNT_W-1:0] i_q, j_q, k_q;
	logic [CNT_W-1:0] i_inc, i_inc2, j_dec, k_inc;

	entry_t held_q;
	res_t   out_q;
	logic   out_vld_q;

	logic               accept;
	logic               swap;
	logic               out_free;
	logic               k_last;
	logic [KEY_W-1:0]   key_value;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	entry_t             mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata_raw;
	entry_t             mem_rdata;

	tas_key_unit u_key (
		.clk    (clk),
		.edge_a (e1_q),
		.edge_b (e2_q),
		.edge_c (e3_q),
		.key    (key_value)
	);

	tas_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_TRIANGLES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata_raw)
	);

	assign mem_rdata = entry_t'(mem_rdata_raw);

	assign i_inc     = i_q + CNT_W'(1);
	assign i_inc2    = i_q + CNT_W'(2);
	assign j_dec     = j_q - CNT_W'(1);
	assign k_inc     = k_q + CNT_W'(1);
	assign cnt_after = count_q + CNT_W'(store_q);
	assign k_last    = (k_inc == count_q);

	assign triangles.ready = (state_q == ST_IDLE);
	assign accept          = triangles.valid && triangles.ready;

	// The result register is free when empty or emptied at this edge.
	assign out_free = !out_vld_q || results.ready;

	// The held entry i and the entry j-1 just read swap only when both keys
	// are non-negative and i has the larger one. Invalid triangles stay put.
	assign swap = !held_q.key[KEY_W-1] && !mem_rdata.key[KEY_W-1] &&
		($signed(held_q.key) > $signed(mem_rdata.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM port control. During the scan the RAM is read one
	// entry ahead of the compare, and the swap writes back the entry behind
	// the one being read, so the ports never meet at one address.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = j_dec[ADDR_W-1:0];
		mem_wdata = held_q;
		mem_raddr = i_q[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_KEY1;
				end
			end
			ST_KEY1: begin
				state_d = ST_KEY2;
			end
			ST_KEY2: begin
				state_d = ST_KEY3;
			end
			ST_KEY3: begin
				mem_we    = store_q;
				mem_waddr = count_q[ADDR_W-1:0];
				mem_wdata = '{e3: e3_q, e2: e2_q, e1: e1_q, key: key_value};
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (cnt_after < CNT_W'(2)) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_RD: begin
				mem_raddr = i_q[ADDR_W-1:0];
				state_d   = ST_SORT_CAP;
			end
			ST_SORT_CAP: begin
				mem_raddr = i_inc[ADDR_W-1:0];
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				mem_we    = swap;
				mem_waddr = j_dec[ADDR_W-1:0];
				mem_raddr = j_q[ADDR_W-1:0];
				if (j_q >= count_q) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				// Entry i is final; the next pass starts with its read here.
				mem_we    = 1'b1;
				mem_waddr = i_q[ADDR_W-1:0];
				mem_raddr = i_inc[ADDR_W-1:0];
				if (i_inc2 < count_q) begin
					state_d = ST_SORT_CAP;
				end else begin
					state_d = ST_OUT_RD;
				end
			end
			ST_OUT_RD: begin
				mem_raddr = k_q[ADDR_W-1:0];
				if (out_free) begin
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				if (k_last) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: count, drop, last and store flags, indexes and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			drop_q    <= 1'b0;
			last_q    <= 1'b0;
			store_q   <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				last_q  <= triangles.data.final_item;
				store_q <= (count_q < CNT_W'(MAX_TRIANGLES));
				if (count_q >= CNT_W'(MAX_TRIANGLES)) begin
					drop_q <= 1'b1;
				end
			end
			if (state_q == ST_KEY3) begin
				count_q <= cnt_after;
				i_q     <= '0;
				k_q     <= '0;
			end
			if (state_q == ST_SORT_CAP) begin
				j_q <= i_inc2;
			end
			if (state_q == ST_SCAN && j_q < count_q) begin
				j_q <= j_q + CNT_W'(1);
			end
			if (state_q == ST_WB) begin
				i_q <= i_inc;
			end
			if (state_q == ST_OUT_LD) begin
				k_q <= k_inc;
				if (k_last) begin
					count_q <= '0;
					drop_q  <= 1'b0;
				end
			end
			if (state_q == ST_OUT_LD) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			e1_q <= triangles.data.edge_one[EDGE_BITS-1:0];
			e2_q <= triangles.data.edge_two[EDGE_BITS-1:0];
			e3_q <= triangles.data.edge_three[EDGE_BITS-1:0];
		end
		if (state_q == ST_SORT_CAP || (state_q == ST_SCAN && swap)) begin
			held_q <= mem_rdata;
		end
		if (state_q == ST_OUT_LD) begin
			out_q.sorted_one   <= FIELD_W'(mem_rdata.e1);
			out_q.sorted_two   <= FIELD_W'(mem_rdata.e2);
			out_q.sorted_three <= FIELD_W'(mem_rdata.e3);
			out_q.not_triangle <= mem_rdata.key[KEY_W-1];
			out_q.run_end      <= k_last;
			out_q.overflowed   <= drop_q;
		end
	end

	assign results.valid = out_vld_q;
	assign results.data  = out_q;

	// The count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRIANGLES))
		else $error("stored count exceeds the store depth");

	// During the scan, j stays beyond i + 1 and does not pass the stored count.
	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((j_q > i_inc) && (j_q <= count_q)))
		else $error("scan index left its window");

	// A result is loaded only into an empty result register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_LD) |-> !out_vld_q)
		else $error("result register overwritten before its transaction");

	// Sort write-backs touch only stored entries.
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_KEY3) |-> (CNT_W'(mem_waddr) < count_q))
		else $error("sort wrote outside the stored set");

endmodule

>>> rtl/core/tas_ram.sv
// ============================================================================
// tas_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
module tas_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/tas_key_unit.sv
// ============================================================================
// tas_key_unit: Heron area key pipeline
// Computes (a+b+c)(-a+b+c)(a-b+c)(a+b-c) in two register stages; the last
// multiplication feeds the store write directly.
// ============================================================================
module tas_key_unit import tas_pkg::*; (
	input  logic                 clk,
	input  logic [EDGE_BITS-1:0] edge_a,
	input  logic [EDGE_BITS-1:0] edge_b,
	input  logic [EDGE_BITS-1:0] edge_c,
	output logic [KEY_W-1:0]     key
);

	localparam int FULL_W = 2 * PROD_W;

	logic signed [SUM_W-1:0]  a_x, b_x, c_x;
	logic signed [SUM_W-1:0]  p_s1, q_s1, r_s1, s_s1;
	logic signed [PROD_W-1:0] pq_s2, rs_s2;
	logic signed [FULL_W-1:0] full;

	assign a_x = $signed({{(SUM_W - EDGE_BITS){1'b0}}, edge_a});
	assign b_x = $signed({{(SUM_W - EDGE_BITS){1'b0}}, edge_b});
	assign c_x = $signed({{(SUM_W - EDGE_BITS){1'b0}}, edge_c});

	always_ff @(posedge clk) begin
		p_s1  <= a_x + b_x + c_x;
		q_s1  <= b_x + c_x - a_x;
		r_s1  <= a_x - b_x + c_x;
		s_s1  <= a_x + b_x - c_x;
		pq_s2 <= PROD_W'(p_s1 * q_s1);
		rs_s2 <= PROD_W'(r_s1 * s_s1);
	end

	assign full = FULL_W'(pq_s2 * rs_s2);
	// The values fit in KEY_W bits, so the narrowing size cast keeps the sign.
	assign key  = KEY_W'(full);

endmodule
